// ----- rtl/phpd_pkg.sv -----
// ----------------------------------------------------------------------------
// phpd_pkg
// Shared types, constants and the near-zone period table builder for the
// proximity haptic pulse driver.
// ----------------------------------------------------------------------------
package phpd_pkg;

	localparam int CHANNELS_DEF   = 3;
	localparam int NEAR_STEPS_DEF = 256;

	localparam int DIST_W   = 16;
	localparam int LIMIT_W  = 8;
	localparam int GAIN_W   = 9;
	localparam int RANGE_W  = 13;
	localparam int CHAN_W   = 2;
	localparam int TIME_W   = 32;
	localparam int DUTY_W   = 8;
	localparam int ZONE_W   = 3;
	localparam int PERIOD_W = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W    = 9;
	localparam int DIV_W    = 32;
	localparam int DVS_W    = 16;

	localparam logic [LIMIT_W-1:0]  NO_ECHO_CM = 8'd200;
	localparam logic [DIST_W-1:0]   DIST_RESET = 16'd51200;
	localparam logic [DUTY_W-1:0]   DUTY_FAR   = 8'd130;
	localparam logic [DUTY_W-1:0]   DUTY_MID   = 8'd180;
	localparam logic [DUTY_W-1:0]   DUTY_NEAR  = 8'd220;
	localparam logic [DUTY_W-1:0]   DUTY_CRIT  = 8'd255;
	localparam logic [PERIOD_W-1:0] PERIOD_FAR = 10'd1000;
	localparam logic [PERIOD_W-1:0] PERIOD_MID = 10'd333;
	localparam logic [GAIN_W-1:0]   GAIN_MAX   = 9'd256;
	// reciprocal of 10 in Q0.16, exact for 13-bit ranges
	localparam logic [RANGE_W-1:0]  RECIP_10   = 13'd6554;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CRIT = 3'd0,
		REG_NEAR = 3'd1,
		REG_MID  = 3'd2,
		REG_FAR  = 3'd3,
		REG_GAIN = 3'd4
	} phpd_reg_t;

	typedef enum logic [ZONE_W-1:0] {
		ZONE_OFF  = 3'd0,
		ZONE_FAR  = 3'd1,
		ZONE_MID  = 3'd2,
		ZONE_NEAR = 3'd3,
		ZONE_CRIT = 3'd4
	} phpd_zone_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RAW,
		S_FILT,
		S_CLASS,
		S_BRANCH,
		S_QWAIT,
		S_ROM,
		S_MDIV,
		S_MWAIT,
		S_DONE
	} phpd_state_t;

	typedef struct packed {
		logic capture;
		logic raw_load;
		logic filt_load;
		logic classify;
		logic div_start;
		logic div_mod;
		logic idx_load;
		logic rom_load;
		logic duty_load;
		logic out_load;
	} phpd_cmd_t;

	typedef struct packed {
		logic bad;
		logic action;
		logic near_div;
		logic pulse;
		logic div_done;
		logic out_free;
	} phpd_sts_t;

	// truncated power of m, capped just above cap
	function automatic logic [63:0] phpd_capped_pow(input logic [63:0] m, input int steps);
		logic [63:0] r;
		logic [63:0] cap;
		r = 64'd1 << 30;
		cap = 64'd3 << 30;
		for (int k = 0; k < steps; k++) begin
			if (r <= cap)
				r = (r * m) >> 30;
		end
		return (r > cap) ? cap + 64'd1 : r;
	endfunction

	// largest Q2.30 step whose power over the table stays at or below three
	function automatic logic [63:0] phpd_near_mult(input int steps);
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] md;
		logic [63:0] cap;
		cap = 64'd3 << 30;
		lo = 64'd1 << 30;
		hi = cap;
		for (int k = 0; k < 40; k++) begin
			if (lo < hi) begin
				md = lo + ((hi - lo + 64'd1) >> 1);
				if (phpd_capped_pow(md, steps) <= cap)
					lo = md;
				else
					hi = md - 64'd1;
			end
		end
		return lo;
	endfunction

	// 250 ms scaled by the inverse power, long division bit by bit
	function automatic logic [PERIOD_W-1:0] phpd_rom_entry(input logic [63:0] m, input int idx);
		logic [63:0] r;
		logic [63:0] q;
		logic [63:0] num;
		logic [64:0] rm;
		r = 64'd1 << 30;
		for (int k = 0; k < idx; k++)
			r = (r * m) >> 30;
		num = 64'd250 << 30;
		q = '0;
		rm = '0;
		for (int b = 63; b >= 0; b--) begin
			rm = {rm[63:0], num[b]};
			if (rm >= {1'b0, r}) begin
				rm = rm - {1'b0, r};
				q[b] = 1'b1;
			end
		end
		return q[PERIOD_W-1:0];
	endfunction

endpackage

// ----- rtl/phpd_div.sv -----
// ----------------------------------------------------------------------------
// phpd_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phpd_div
	import phpd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot,
	output logic [DVS_W-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quot_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic             fits;
	logic [DVS_W:0]   diff;

	assign shifted = {rem_q, quot_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DIV_W-2:0], fits};
			rem_q  <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/phpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// phpd_ctrl
// Sequencer: steps one item through filter, classification and divisions.
// ----------------------------------------------------------------------------
module phpd_ctrl
	import phpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  phpd_sts_t sts,
	output phpd_cmd_t cmd
);

	phpd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_RAW;
				end
			end
			S_RAW: begin
				priority if (sts.bad)
					state_d = S_DONE;
				else if (sts.action) begin
					cmd.raw_load = 1'b1;
					state_d = S_FILT;
				end else
					state_d = S_CLASS;
			end
			S_FILT: begin
				cmd.filt_load = 1'b1;
				state_d = S_CLASS;
			end
			S_CLASS: begin
				cmd.classify = 1'b1;
				state_d = S_BRANCH;
			end
			S_BRANCH: begin
				priority if (sts.near_div) begin
					cmd.div_start = 1'b1;
					state_d = S_QWAIT;
				end else if (sts.pulse) begin
					cmd.div_start = 1'b1;
					cmd.div_mod = 1'b1;
					state_d = S_MWAIT;
				end else
					state_d = S_DONE;
			end
			S_QWAIT: begin
				if (sts.div_done) begin
					cmd.idx_load = 1'b1;
					state_d = S_ROM;
				end
			end
			S_ROM: begin
				cmd.rom_load = 1'b1;
				state_d = S_MDIV;
			end
			S_MDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_mod = 1'b1;
				state_d = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.div_done) begin
					cmd.duty_load = 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/phpd_dp.sv -----
// ----------------------------------------------------------------------------
// phpd_dp
// Datapath: config registers, per-channel filter state, zone logic, period
// table, shared divider and the output register.
// ----------------------------------------------------------------------------
module phpd_dp
	import phpd_pkg::*;
#(
	parameter int CHANNELS         = CHANNELS_DEF,
	parameter int NEAR_TABLE_STEPS = NEAR_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 action,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [RANGE_W-1:0]   range_mm,
	input  logic                 out_of_range,
	input  logic                 sensor_ok,
	input  logic [TIME_W-1:0]    time_ms,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [DUTY_W-1:0]    duty,
	output logic [ZONE_W-1:0]    zone,
	output logic [LIMIT_W-1:0]   filtered_cm,
	input  phpd_cmd_t            cmd,
	output phpd_sts_t            sts
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int IDX_W = $clog2(NEAR_TABLE_STEPS + 1);
	localparam logic [63:0] NEAR_MULT = phpd_near_mult(NEAR_TABLE_STEPS);

	// config
	logic [LIMIT_W-1:0] crit_q, near_q, mid_q, far_q;
	logic [GAIN_W-1:0]  gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q <= 8'd10;
			near_q <= 8'd25;
			mid_q  <= 8'd50;
			far_q  <= 8'd100;
			gain_q <= 9'd102;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CRIT: crit_q <= cfg_data[LIMIT_W-1:0];
				REG_NEAR: near_q <= cfg_data[LIMIT_W-1:0];
				REG_MID:  mid_q  <= cfg_data[LIMIT_W-1:0];
				REG_FAR:  far_q  <= cfg_data[LIMIT_W-1:0];
				REG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// period table, constant
	logic [PERIOD_W-1:0] rom_w [NEAR_TABLE_STEPS+1];
	for (genvar k = 0; k <= NEAR_TABLE_STEPS; k++) begin : g_rom
		localparam logic [PERIOD_W-1:0] ENTRY = phpd_rom_entry(NEAR_MULT, k);
		assign rom_w[k] = ENTRY;
	end

	// captured item
	logic                action_q, bad_q, oor_q, ok_q;
	logic [CH_W-1:0]     ch_q;
	logic [RANGE_W-1:0]  range_q;
	logic [TIME_W-1:0]   time_q;
	logic [DIST_W-1:0]   dist_q [CHANNELS];
	logic [DIST_W-1:0]   d_q;
	logic [LIMIT_W-1:0]  raw_q;
	logic [ZONE_W-1:0]   zone_q;
	logic [DUTY_W-1:0]   level_q, duty_q;
	logic [PERIOD_W-1:0] period_q;
	logic                near_div_q, pulse_q;
	logic [DIV_W-1:0]    num_q;
	logic [DVS_W-1:0]    den_q;
	logic [IDX_W-1:0]    idx_q;
	logic                out_valid_q;
	logic [DUTY_W-1:0]   duty_o_q;
	logic [ZONE_W-1:0]   zone_o_q;
	logic [LIMIT_W-1:0]  fcm_o_q;

	logic chan_bad;
	assign chan_bad = 32'(channel) >= CHANNELS;

	// range to cm by reciprocal multiply
	logic [2*RANGE_W-1:0] range_prod;
	logic [RANGE_W-1:0]   range_cm;
	logic [LIMIT_W-1:0]   raw_d;
	assign range_prod = range_q * RECIP_10;
	assign range_cm   = RANGE_W'(range_prod[2*RANGE_W-1:16]);
	assign raw_d = (!ok_q || oor_q) ? NO_ECHO_CM :
		((range_cm > RANGE_W'(NO_ECHO_CM)) ? NO_ECHO_CM : range_cm[LIMIT_W-1:0]);

	// filter update, arithmetic shift floors the step
	logic [GAIN_W-1:0]   g;
	logic signed [17:0]  fdiff;
	logic signed [27:0]  fprod;
	logic signed [19:0]  fdelta;
	logic signed [19:0]  fsum;
	logic [DIST_W-1:0]   d_new;
	assign g      = (gain_q > GAIN_MAX) ? GAIN_MAX : gain_q;
	assign fdiff  = $signed({2'b00, raw_q, 8'h00}) - $signed({2'b00, d_q});
	assign fprod  = $signed({1'b0, g}) * fdiff;
	assign fdelta = 20'(fprod >>> 8);
	assign fsum   = $signed({4'h0, d_q}) + fdelta;
	assign d_new  = fsum[19] ? '0 : (|fsum[18:16] ? '1 : fsum[DIST_W-1:0]);

	// zone limits in Q8.8
	logic [DIST_W-1:0] crit_l, near_l, mid_l, far_l;
	logic [DIST_W-1:0] near_span;
	assign crit_l = {crit_q, 8'h00};
	assign near_l = {near_q, 8'h00};
	assign mid_l  = {mid_q, 8'h00};
	assign far_l  = {far_q, 8'h00};
	assign near_span = near_l - d_q;

	logic [DIV_W-1:0] div_a;
	logic [DVS_W-1:0] div_b;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;
	logic [DVS_W-1:0] div_rem;

	assign div_a = cmd.div_mod ? time_q : num_q;
	assign div_b = cmd.div_mod ? DVS_W'(period_q) : den_q;

	phpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++)
				dist_q[c] <= DIST_RESET;
		end else if (cmd.filt_load) begin
			dist_q[ch_q] <= d_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			bad_q    <= chan_bad;
			ch_q     <= CH_W'(channel);
			range_q  <= range_mm;
			oor_q    <= out_of_range;
			ok_q     <= sensor_ok;
			time_q   <= time_ms;
			d_q      <= chan_bad ? '0 : dist_q[CH_W'(channel)];
			zone_q   <= ZONE_OFF;
			duty_q   <= '0;
		end
		if (cmd.raw_load)
			raw_q <= raw_d;
		if (cmd.filt_load)
			d_q <= d_new;
		if (cmd.classify) begin
			near_div_q <= 1'b0;
			pulse_q    <= 1'b0;
			level_q    <= '0;
			duty_q     <= '0;
			period_q   <= rom_w[NEAR_TABLE_STEPS];
			num_q      <= DIV_W'(near_span) * DIV_W'(NEAR_TABLE_STEPS);
			den_q      <= {near_q - crit_q, 8'h00};
			priority if (d_q >= far_l)
				zone_q <= ZONE_OFF;
			else if (d_q <= crit_l) begin
				zone_q <= ZONE_CRIT;
				duty_q <= DUTY_CRIT;
			end else if (d_q <= near_l) begin
				zone_q  <= ZONE_NEAR;
				level_q <= DUTY_NEAR;
				pulse_q <= 1'b1;
				near_div_q <= near_q > crit_q;
			end else if (d_q <= mid_l) begin
				zone_q   <= ZONE_MID;
				level_q  <= DUTY_MID;
				period_q <= PERIOD_MID;
				pulse_q  <= 1'b1;
			end else begin
				zone_q   <= ZONE_FAR;
				level_q  <= DUTY_FAR;
				period_q <= PERIOD_FAR;
				pulse_q  <= 1'b1;
			end
		end
		if (cmd.idx_load)
			idx_q <= (div_quot > DIV_W'(NEAR_TABLE_STEPS)) ?
				IDX_W'(NEAR_TABLE_STEPS) : div_quot[IDX_W-1:0];
		if (cmd.rom_load)
			period_q <= rom_w[idx_q];
		if (cmd.duty_load)
			duty_q <= (div_rem < DVS_W'(period_q >> 1)) ? level_q : '0;
		if (cmd.out_load) begin
			duty_o_q <= duty_q;
			zone_o_q <= zone_q;
			fcm_o_q  <= d_q[DIST_W-1:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign sts.bad      = bad_q;
	assign sts.action   = action_q;
	assign sts.near_div = near_div_q;
	assign sts.pulse    = pulse_q;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign duty        = duty_o_q;
	assign zone        = zone_o_q;
	assign filtered_cm = fcm_o_q;

endmodule

// ----- rtl/proximity_haptic_pulse_driver.sv -----
// ----------------------------------------------------------------------------
// proximity_haptic_pulse_driver
// Per-channel distance filter and pulsed vibration duty generator.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry one channel's range sample or time
// tick; each produces exactly one output beat (out_valid/out_ready) with the
// duty, the zone and the filtered distance in whole cm.
// Items are handled one at a time. A sample beat in the far or mid zone has
// its result loaded after one pass of the 32-step shared divider for time
// mod period, and in the near zone after two passes, where the same divider
// first finds the table position and then the remainder. Off and critical
// results skip the divider. A tick beat skips the filter state, and a bad
// channel number goes straight to the result. The next beat is accepted the
// cycle after the result loads.
// Finished results sit in an output register, so the next beat is accepted
// while the previous result still waits; if the receiver stalls, the block
// holds its next result until the register frees.
// Reset sets the limits to 10/25/50/100 cm, the gain to 102 and all filtered
// distances to 200 cm. Configuration writes take effect at once; the user
// must make them while no beat is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module proximity_haptic_pulse_driver
	import phpd_pkg::*;
#(
	parameter int CHANNELS         = CHANNELS_DEF,
	parameter int NEAR_TABLE_STEPS = NEAR_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  logic [CHAN_W-1:0]    channel,
	input  logic [RANGE_W-1:0]   range_mm,
	input  logic                 out_of_range,
	input  logic                 sensor_ok,
	input  logic [TIME_W-1:0]    time_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DUTY_W-1:0]    duty,
	output logic [ZONE_W-1:0]    zone,
	output logic [LIMIT_W-1:0]   filtered_cm
);

	phpd_cmd_t cmd;
	phpd_sts_t sts;

	phpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	phpd_dp #(
		.CHANNELS         (CHANNELS),
		.NEAR_TABLE_STEPS (NEAR_TABLE_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.channel      (channel),
		.range_mm     (range_mm),
		.out_of_range (out_of_range),
		.sensor_ok    (sensor_ok),
		.time_ms      (time_ms),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.duty         (duty),
		.zone         (zone),
		.filtered_cm  (filtered_cm),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

// ----- rtl/phpd_checker.sv -----
// ----------------------------------------------------------------------------
// phpd_checker
// Port-level checks on the result beats of the pulse driver.
// ----------------------------------------------------------------------------
module phpd_checker
	import phpd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [DUTY_W-1:0]    duty,
	input logic [ZONE_W-1:0]    zone,
	input logic [LIMIT_W-1:0]   filtered_cm
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(zone)
			&& $stable(filtered_cm))
		else $error("result beat changed while stalled");

	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zone == ZONE_OFF |-> duty == '0)
		else $error("off zone with nonzero duty");

	a_crit_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zone == ZONE_CRIT |-> duty == DUTY_CRIT)
		else $error("critical zone without full duty");

	a_pulse_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (zone == ZONE_FAR || zone == ZONE_MID || zone == ZONE_NEAR) |->
			(duty == '0 || duty == DUTY_FAR || duty == DUTY_MID || duty == DUTY_NEAR))
		else $error("pulsing zone with unexpected duty");

	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zone <= ZONE_CRIT && filtered_cm <= NO_ECHO_CM)
		else $error("zone or distance out of range");

endmodule

bind proximity_haptic_pulse_driver phpd_checker u_phpd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.duty        (duty),
	.zone        (zone),
	.filtered_cm (filtered_cm)
);

// ----- test/proximity_haptic_pulse_driver_tb.sv -----
// ----------------------------------------------------------------------------
// proximity_haptic_pulse_driver_tb
// Drives sample and tick beats into the pulse driver. A local copy of the
// filter, zone logic and near-period table predicts every result, and each
// output beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module proximity_haptic_pulse_driver_tb
	import phpd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCH = 3;
	localparam int STEPS = 256;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [DUTY_W-1:0]  duty;
		logic [ZONE_W-1:0]  zone;
		logic [LIMIT_W-1:0] fcm;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = 1'b0;
	logic [CHAN_W-1:0] channel = '0;
	logic [RANGE_W-1:0] range_mm = '0;
	logic out_of_range = 1'b0;
	logic sensor_ok = 1'b0;
	logic [TIME_W-1:0] time_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DUTY_W-1:0] duty;
	logic [ZONE_W-1:0] zone;
	logic [LIMIT_W-1:0] filtered_cm;

	proximity_haptic_pulse_driver uut (.*);

	initial forever #5 clk = ~clk;

	// predictor state
	logic [15:0] dist_q88 [NCH];
	logic [7:0] lim_crit, lim_near, lim_mid, lim_far;
	logic [8:0] gain;
	logic [15:0] near_period [STEPS+1];
	drive_t pending_drive [$];

	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet = 0;

	task automatic build_period_table();
		longint unsigned lo, hi, md, r, cap;
		int k;
		cap = 64'd3 << 30;
		lo = 64'd1 << 30;
		hi = cap;
		while (lo < hi) begin
			md = lo + (hi - lo + 1) / 2;
			r = 64'd1 << 30;
			for (k = 0; k < STEPS && r <= cap; k++)
				r = (r * md) >> 30;
			if (r <= cap)
				lo = md;
			else
				hi = md - 1;
		end
		r = 64'd1 << 30;
		for (k = 0; k <= STEPS; k++) begin
			near_period[k] = 16'((64'd250 << 30) / r);
			r = (r * lo) >> 30;
		end
	endtask

	function automatic drive_t predict_drive(logic act, logic [1:0] ch, logic [12:0] rng,
			logic oor, logic ok, logic [31:0] now);
		drive_t res;
		longint d, raw, prod, delta, g, num, den, idx;
		int unsigned period, level;
		res.duty = 0;
		res.zone = ZONE_OFF;
		res.fcm = 0;
		period = 0;
		level = 0;
		if (ch >= NCH)
			return res;
		d = dist_q88[ch];
		if (act) begin
			g = (gain > 256) ? 256 : gain;
			raw = 200;
			if (ok && !oor) begin
				raw = rng / 10;
				if (raw > 200) raw = 200;
			end
			prod = g * (raw * 256 - d);
			delta = (prod >= 0) ? (prod >>> 8) : -((-prod + 255) >>> 8);
			d = d + delta;
			if (d < 0) d = 0;
			if (d > 65535) d = 65535;
			dist_q88[ch] = 16'(d);
		end
		if (d >= lim_far * 256) begin
			res.zone = ZONE_OFF;
		end else if (d <= lim_crit * 256) begin
			res.zone = ZONE_CRIT;
			res.duty = DUTY_CRIT;
		end else if (d <= lim_near * 256) begin
			res.zone = ZONE_NEAR;
			level = DUTY_NEAR;
			if (lim_near > lim_crit) begin
				num = (lim_near * 256 - d) * STEPS;
				den = (lim_near - lim_crit) * 256;
				idx = num / den;
				if (idx > STEPS) idx = STEPS;
				period = near_period[idx];
			end else begin
				period = near_period[STEPS];
			end
		end else if (d <= lim_mid * 256) begin
			res.zone = ZONE_MID;
			level = DUTY_MID;
			period = PERIOD_MID;
		end else begin
			res.zone = ZONE_FAR;
			level = DUTY_FAR;
			period = PERIOD_FAR;
		end
		if (period != 0)
			res.duty = ((now % period) < (period / 2)) ? 8'(level) : 8'd0;
		res.fcm = 8'(d >> 8);
		return res;
	endfunction

	// valid stays up after a beat until the next beat or an idle cycle
	task automatic send_beat(logic act, logic [1:0] ch, logic [12:0] rng,
			logic oor, logic ok, logic [31:0] now);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		channel <= ch;
		range_mm <= rng;
		out_of_range <= oor;
		sensor_ok <= ok;
		time_ms <= now;
		do @(posedge clk); while (!in_ready);
		pending_drive.push_back(predict_drive(act, ch, rng, oor, ok, now));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(phpd_reg_t idx, logic [8:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_CRIT: lim_crit = val[7:0];
			REG_NEAR: lim_near = val[7:0];
			REG_MID:  lim_mid = val[7:0];
			REG_FAR:  lim_far = val[7:0];
			REG_GAIN: gain = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(logic [7:0] c, logic [7:0] n, logic [7:0] m, logic [7:0] f,
			logic [8:0] g);
		drain();
		write_reg(REG_CRIT, {1'b0, c});
		write_reg(REG_NEAR, {1'b0, n});
		write_reg(REG_MID, {1'b0, m});
		write_reg(REG_FAR, {1'b0, f});
		write_reg(REG_GAIN, g);
		cfg_we <= 1'b0;
	endtask

	// random time, half the draws within 0..2000 to cover short periods
	function automatic logic [31:0] rand_time();
		return ($urandom_range(1)) ? $urandom() : $urandom_range(2000);
	endfunction

	task automatic send_random(int n);
		logic [12:0] r;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: r = $urandom();
				1: r = $urandom_range(2100);
				default: r = $urandom_range(lim_far * 10 + 40);
			endcase
			send_beat($urandom_range(9) < 7, ($urandom_range(15) == 0) ? 2'd3 :
				2'($urandom_range(NCH - 1)), r, $urandom_range(9) == 0,
				$urandom_range(9) != 0, rand_time());
		end
	endtask

	task automatic test_directed();
		send_beat(1'b0, 2'd0, 13'd0, 1'b0, 1'b1, 32'd0);
		send_beat(1'b1, 2'd0, 13'd0, 1'b0, 1'b1, 32'hFFFF_FFFF);
		send_beat(1'b1, 2'd1, 13'h1FFF, 1'b0, 1'b1, 32'd499);
		send_beat(1'b1, 2'd2, 13'd300, 1'b1, 1'b1, 32'd500);
		send_beat(1'b1, 2'd2, 13'd300, 1'b0, 1'b0, 32'd1);
		send_beat(1'b1, 2'd3, 13'h1FFF, 1'b1, 1'b0, 32'hAAAA_5555);
		send_beat(1'b0, 2'd3, 13'd0, 1'b0, 1'b1, 32'd0);
		for (int i = 0; i < 14; i++)
			send_beat(1'b1, 2'd0, 13'(i * 20), 1'b0, 1'b1, 32'(i * 37));
		send_beat(1'b0, 2'd0, 13'd0, 1'b0, 1'b1, 32'd165);
		send_beat(1'b0, 2'd0, 13'd0, 1'b0, 1'b1, 32'd166);
	endtask

	task automatic test_gain_extremes();
		set_limits(8'd10, 8'd25, 8'd50, 8'd100, 9'd256);
		send_beat(1'b1, 2'd1, 13'd150, 1'b0, 1'b1, 32'd10);
		send_beat(1'b1, 2'd1, 13'd1900, 1'b0, 1'b1, 32'd20);
		set_limits(8'd10, 8'd25, 8'd50, 8'd100, 9'd511);
		send_beat(1'b1, 2'd1, 13'd120, 1'b0, 1'b1, 32'd30);
		set_limits(8'd10, 8'd25, 8'd50, 8'd100, 9'd0);
		send_random(15);
	endtask

	task automatic test_limit_settings();
		set_limits(8'd1, 8'd2, 8'd3, 8'd4, 9'd200);
		send_random(30);
		set_limits(8'd200, 8'd200, 8'd200, 8'd200, 9'd102);
		send_random(20);
		set_limits(8'd60, 8'd30, 8'd255, 8'd20, 9'd150);
		send_random(20);
		set_limits(8'd0, 8'd255, 8'd255, 8'd255, 9'd128);
		send_random(30);
		set_limits(8'd10, 8'd150, 8'd180, 8'd200, 9'd180);
	endtask

	task automatic test_random_phases();
		idle_pct = 0;   stall_pct = 0;  send_random(70);
		idle_pct = 46;  stall_pct = 0;  send_random(70);
		idle_pct = 0;   stall_pct = 46; send_random(70);
		idle_pct = 27;  stall_pct = 27; send_random(70);
		idle_pct = 0;   stall_pct = 0;
	endtask

	// result checker
	always @(posedge clk) begin
		drive_t want;
		if (out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				$display("%t unexpected beat: duty %0d zone %0d cm %0d", $realtime,
					duty, zone, filtered_cm);
				errors++;
			end else begin
				want = pending_drive.pop_front();
				if (duty !== want.duty) begin
					$display("%t duty: expected %0d actual %0d", $realtime, want.duty, duty);
					errors++;
				end
				if (zone !== want.zone) begin
					$display("%t zone: expected %0d actual %0d", $realtime, want.zone, zone);
					errors++;
				end
				if (filtered_cm !== want.fcm) begin
					$display("%t filtered_cm: expected %0d actual %0d", $realtime,
						want.fcm, filtered_cm);
					errors++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog on beats
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		lim_crit = 8'd10;
		lim_near = 8'd25;
		lim_mid = 8'd50;
		lim_far = 8'd100;
		gain = 9'd102;
		for (int c = 0; c < NCH; c++)
			dist_q88[c] = DIST_RESET;
		build_period_table();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_gain_extremes();
		test_limit_settings();
		test_random_phases();
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/phpd_pkg.sv
rtl/phpd_div.sv
rtl/phpd_ctrl.sv
rtl/phpd_dp.sv
rtl/proximity_haptic_pulse_driver.sv
rtl/phpd_checker.sv
test/proximity_haptic_pulse_driver_tb.sv
